// ----- rtl/core/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache core.
package lkv_pkg;

	// Default sizing handed to the top level parameters
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Capacity register
	localparam int             CFG_BITS  = 5;
	localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// Queue head status seen by the back end
	typedef struct packed {
		logic valid;
		logic op;
	} lkv_head_t;

endpackage

// ----- rtl/core/lkv_ram.sv -----
// Generic single-port RAM with registered read data.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read, one access per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/core/lkv_front.sv -----
// Command front end: accepts requests, decodes the operation and queues them.
module lkv_front
	import lkv_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  pop,
	output lkv_head_t             head,
	output logic [KEY_BITS-1:0]   head_key,
	output logic [VALUE_BITS-1:0] head_value
);

	logic                  is_set_q [QUEUE_DEPTH];
	logic [KEY_BITS-1:0]   key_q    [QUEUE_DEPTH];
	logic [VALUE_BITS-1:0] value_q  [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  cnt_q;
	logic                  accept;
	logic                  do_pop;

	assign busy   = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign accept = start && !busy;
	assign do_pop = pop && (cnt_q != '0);

	// Queue head toward the back end
	assign head.valid = (cnt_q != '0);
	assign head.op    = is_set_q[rd_ptr_q] ? OP_SET : OP_GET;
	assign head_key   = key_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (accept && !do_pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (do_pop && !accept) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	// Queue payload, classified on entry
	always_ff @(posedge clk) begin
		if (accept) begin
			is_set_q[wr_ptr_q] <= (operation == OP_SET);
			key_q[wr_ptr_q]    <= key;
			value_q[wr_ptr_q]  <= value;
		end
	end

endmodule

// ----- rtl/core/lkv_back.sv -----
// Back end: associative lookup, recency update, fill and eviction.
module lkv_back
	import lkv_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CFG_BITS-1:0]   cap,
	input  lkv_head_t             head,
	input  logic [KEY_BITS-1:0]   head_key,
	input  logic [VALUE_BITS-1:0] head_value,
	output logic                  pop,
	output logic                  done,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > CFG_BITS) ? UW : CFG_BITS;

	typedef enum logic {ST_LOOK, ST_COMMIT} state_t;

	state_t                state_q;
	logic [KEY_BITS-1:0]   keys_q [ENTRIES];
	logic [IW-1:0]         rank_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [UW-1:0]         used_q;

	// Lookup stage registers
	logic                  op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [ENTRIES-1:0]    match_s1;
	logic [ENTRIES-1:0]    lru_s1;

	// Response registers
	logic                  rsp_q;
	logic                  rsp_hit_q;

	logic [ENTRIES-1:0]    match;
	logic [ENTRIES-1:0]    lru;
	logic [ENTRIES-1:0]    fill_oh;
	logic [ENTRIES-1:0]    tgt;
	logic [IW-1:0]         tgt_idx;
	logic [IW-1:0]         tgt_rank;
	logic [IW-1:0]         rank_d [ENTRIES];
	logic [UW-1:0]         used_m1;
	logic [IW-1:0]         lru_rank;
	logic [CW-1:0]         cap_sat;
	logic                  commit;
	logic                  hit_any;
	logic                  is_set;
	logic                  room;
	logic                  do_fill;
	logic                  do_evict;
	logic                  do_touch;
	logic                  wr_key;
	logic                  wr_val;
	logic                  ram_en;
	logic [VALUE_BITS-1:0] ram_rdata;

	assign pop    = (state_q == ST_LOOK) && head.valid;
	assign commit = (state_q == ST_COMMIT);

	// Oldest valid entry carries rank used_count - 1
	assign used_m1  = used_q - UW'(1);
	assign lru_rank = used_m1[IW-1:0];

	// Per-entry key compare and LRU detect
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]   = valid_q[i] && (keys_q[i] == head_key);
			lru[i]     = valid_q[i] && (rank_q[i] == lru_rank);
			fill_oh[i] = (used_q[IW-1:0] == IW'(i));
		end
	end

	// Capacity saturates at the number of entries
	assign cap_sat = (CW'(cap) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap);

	// Commit decision; valid entries always occupy slots 0 .. used_count - 1
	assign hit_any  = |match_s1;
	assign is_set   = (op_s1 == OP_SET);
	assign room     = (CW'(used_q) < cap_sat);
	assign do_fill  = is_set && !hit_any && room;
	assign do_evict = is_set && !hit_any && !room && (used_q != '0);
	assign do_touch = hit_any || do_evict;
	assign wr_key   = do_fill || do_evict;
	assign wr_val   = is_set && (hit_any || do_fill || do_evict);
	assign tgt      = hit_any ? match_s1 : (do_fill ? fill_oh : lru_s1);

	// One-hot target to index and its current rank
	always_comb begin
		tgt_idx  = '0;
		tgt_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tgt[i]) begin
				tgt_idx  = tgt_idx | IW'(i);
				tgt_rank = tgt_rank | rank_q[i];
			end
		end
	end

	// Next recency ranks
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (tgt[i]) begin
				rank_d[i] = '0;
			end else if (valid_q[i] && (do_fill || (do_touch && rank_q[i] < tgt_rank))) begin
				rank_d[i] = rank_q[i] + IW'(1);
			end else begin
				rank_d[i] = rank_q[i];
			end
		end
	end

	assign ram_en = commit && (wr_val || (!is_set && hit_any));

	lkv_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(ENTRIES)
	) u_values (
		.clk   (clk),
		.en    (ram_en),
		.we    (wr_val),
		.addr  (tgt_idx),
		.wdata (value_s1),
		.rdata (ram_rdata)
	);

	// Sequencer, control state and response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOOK;
			valid_q   <= '0;
			used_q    <= '0;
			rsp_q     <= 1'b0;
			rsp_hit_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			rsp_q <= 1'b0;
			case (state_q)
				ST_LOOK: begin
					if (head.valid) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_LOOK;
					if (!is_set) begin
						rsp_q     <= 1'b1;
						rsp_hit_q <= hit_any;
					end
					if (hit_any || do_fill || do_evict) begin
						for (int i = 0; i < ENTRIES; i++) begin
							rank_q[i] <= rank_d[i];
						end
					end
					if (do_fill) begin
						valid_q <= valid_q | fill_oh;
						used_q  <= used_q + UW'(1);
					end
				end
				default: begin
					state_q <= ST_LOOK;
				end
			endcase
		end
	end

	// Lookup stage payload and key store
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head.op;
			key_s1   <= head_key;
			value_s1 <= head_value;
			match_s1 <= match;
			lru_s1   <= lru;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (commit && wr_key && tgt[i]) begin
				keys_q[i] <= key_s1;
			end
		end
	end

	assign done       = rsp_q;
	assign hit        = rsp_hit_q;
	assign read_value = rsp_hit_q ? ram_rdata : '0;

endmodule

// ----- rtl/core/lru_key_value_cache_core.sv -----
// Top level of the fully associative LRU key-value cache.
//
// Command channel: a request (operation, key, value) is taken at a rising
// edge where start is high and busy is low. A two-deep queue sits behind
// the port, so busy only rises when two requests are waiting.
// Result channel: each get yields one result (hit, read_value) shown for a
// single cycle with done high; a set yields none. A miss shows hit low and
// read_value zero. The receiver always takes the result.
// Config channel: cfg_data sets the capacity (entries held before eviction
// starts, saturating at ENTRIES); cfg_ready is always high. Write it while
// the block is idle.
// Timing: a request goes through a lookup state (key compared against all
// entries at once) and a commit state (recency ranks, key and value store
// updated); the result shows on the cycle after commit. The back end takes
// a new request from the queue only after the previous one has committed.
// Reset: all entries invalid, used count zero, capacity 16, queue empty;
// no clearing pass is needed.
module lru_key_value_cache_core
	import lkv_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic signed [KEY_BITS-1:0]   key,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         done,
	output logic                         hit,
	output logic signed [VALUE_BITS-1:0] read_value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_BITS-1:0]          cfg_data
);

	logic [CFG_BITS-1:0]   cap_q;
	lkv_head_t             head;
	logic [KEY_BITS-1:0]   head_key;
	logic [VALUE_BITS-1:0] head_value;
	logic                  pop;
	logic [VALUE_BITS-1:0] rd_value;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	lkv_front #(
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.pop        (pop),
		.head       (head),
		.head_key   (head_key),
		.head_value (head_value)
	);

	lkv_back #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.head       (head),
		.head_key   (head_key),
		.head_value (head_value),
		.pop        (pop),
		.done       (done),
		.hit        (hit),
		.read_value (rd_value)
	);

	assign read_value = rd_value;

endmodule

// ----- rtl/core/lkv_checker.sv -----
// Port-level checks for the LRU key-value cache core, bound to the top level.
module lkv_checker
	import lkv_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  busy,
	input logic                  done,
	input logic                  hit,
	input logic [VALUE_BITS-1:0] read_value
);

	// Results never come back to back
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result transactions");

	// A miss carries a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (read_value == '0))
		else $error("miss result with nonzero value");

	// Right after reset the block is quiet and ready
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> (!done && !busy))
		else $error("activity right after reset");

endmodule

bind lru_key_value_cache_core lkv_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.read_value (read_value)
);

// ----- tb/lru_key_value_cache_core_tb.sv -----
// Self-checking testbench for the LRU key-value cache core: driver, monitor and cache predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
	import lkv_pkg::*;

	localparam int KW          = KEY_BITS_DEF;
	localparam int VW          = VALUE_BITS_DEF;
	localparam int LINES       = ENTRIES_DEF;
	localparam int TAIL_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 32;

	typedef struct {
		logic                 op;
		logic signed [KW-1:0] key;
		logic signed [VW-1:0] val;
	} request_t;

	typedef struct {
		logic                 hit;
		logic signed [VW-1:0] data;
	} lookup_t;

	// DUT ports
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 busy;
	logic                 operation  = OP_GET;
	logic signed [KW-1:0] key        = '0;
	logic signed [VW-1:0] value      = '0;
	logic                 done;
	logic                 hit;
	logic signed [VW-1:0] read_value;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_BITS-1:0]  cfg_data   = '0;

	// Stimulus and scoreboard
	request_t             pending_requests[$];
	lookup_t              expected_lookups[$];
	request_t             current_req;
	logic signed [KW-1:0] key_pool[POOL_SIZE];
	int                   gap_pct       = 0;
	int                   error_count   = 0;
	int                   accepted_count = 0;
	int                   hit_count     = 0;
	int                   miss_count    = 0;
	int                   cap_writes    = 0;
	int                   cycle_count   = 0;

	// Predicted cache contents
	logic signed [KW-1:0] line_key[LINES];
	logic signed [VW-1:0] line_val[LINES];
	logic                 line_valid[LINES];
	int                   line_rank[LINES];
	int                   lines_used;
	logic [CFG_BITS-1:0]  capacity_reg;

	lru_key_value_cache_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// Make line s the most recent; newer valid lines age by one
	task automatic promote_line(input int s);
		int r;
		r = line_rank[s];
		for (int i = 0; i < LINES; i++) begin
			if (line_valid[i] && i != s && line_rank[i] < r)
				line_rank[i]++;
		end
		line_rank[s] = 0;
	endtask

	// Update the predicted cache for one accepted transaction
	task automatic apply_request(input request_t r);
		int      slot;
		int      free_slot;
		int      victim;
		int      lim;
		lookup_t ans;
		lim  = (capacity_reg > LINES) ? LINES : int'(capacity_reg);
		slot = -1;
		for (int i = 0; i < LINES; i++) begin
			if (slot < 0 && line_valid[i] && line_key[i] == r.key)
				slot = i;
		end
		if (r.op == OP_GET) begin
			if (slot >= 0) begin
				promote_line(slot);
				ans.hit  = 1'b1;
				ans.data = line_val[slot];
			end else begin
				ans.hit  = 1'b0;
				ans.data = '0;
			end
			expected_lookups.push_back(ans);
		end else if (slot >= 0) begin
			// update in place
			line_val[slot] = r.val;
			promote_line(slot);
		end else if (lines_used < lim) begin
			// fill the first free line
			free_slot = -1;
			for (int i = 0; i < LINES; i++) begin
				if (free_slot < 0 && !line_valid[i])
					free_slot = i;
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < LINES; i++) begin
					if (line_valid[i])
						line_rank[i]++;
				end
				line_valid[free_slot] = 1'b1;
				line_key[free_slot]   = r.key;
				line_val[free_slot]   = r.val;
				line_rank[free_slot]  = 0;
				lines_used++;
			end
		end else if (lines_used != 0) begin
			// evict the least recent line
			victim = -1;
			for (int i = 0; i < LINES; i++) begin
				if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim]))
					victim = i;
			end
			if (victim >= 0) begin
				line_key[victim] = r.key;
				line_val[victim] = r.val;
				promote_line(victim);
			end
		end
	endtask

	// Driver: present queued requests, with random sender gaps
	always @(posedge clk) begin
		if (!start || !busy) begin
			if (start) begin
				apply_request(current_req);
				accepted_count++;
			end
			if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
				current_req = pending_requests.pop_front();
				operation  <= current_req.op;
				key        <= current_req.key;
				value      <= current_req.val;
				start      <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result with the oldest expected lookup
	always @(posedge clk) begin
		lookup_t exp_l;
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				$display("%0t: unexpected result hit=%0b read_value=%h",
					$time, hit, read_value);
				error_count++;
			end else begin
				exp_l = expected_lookups.pop_front();
				if (exp_l.hit) hit_count++;
				else miss_count++;
				if (hit !== exp_l.hit) begin
					$display("%0t: hit mismatch expected %0b actual %0b",
						$time, exp_l.hit, hit);
					error_count++;
				end
				if (read_value !== exp_l.data) begin
					$display("%0t: read_value mismatch expected %h actual %h",
						$time, exp_l.data, read_value);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d lookups outstanding", $time, expected_lookups.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_request(input logic op, input logic signed [KW-1:0] k,
			input logic signed [VW-1:0] v);
		request_t r;
		r.op  = op;
		r.key = k;
		r.val = v;
		pending_requests.push_back(r);
	endtask

	// Capacity write; only called while the block is idle
	task automatic write_capacity(input logic [CFG_BITS-1:0] c);
		cfg_data  <= c;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = c;
		cap_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold until every request is taken and every lookup answered, then let the pipe empty
	task automatic drain;
		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input logic [CFG_BITS-1:0] c, input int gap, input int count,
			input int span);
		logic signed [KW-1:0] k;
		write_capacity(c);
		gap_pct = gap;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0) k = $urandom;
			else k = key_pool[$urandom_range(span - 1)];
			push_request(1'($urandom_range(1)), k, $urandom);
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_key[i]   = '0;
			line_val[i]   = '0;
			line_valid[i] = 1'b0;
			line_rank[i]  = 0;
		end
		lines_used   = 0;
		capacity_reg = CAP_RESET;

		key_pool[0] = {1'b1, {(KW-1){1'b0}}};
		key_pool[1] = {1'b0, {(KW-1){1'b1}}};
		key_pool[2] = '0;
		key_pool[3] = '1;
		for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// capacity zero on an empty cache: sets store nothing
		write_capacity(0);
		push_request(OP_GET, '0, '0);
		push_request(OP_SET, 32'sd5, 32'sd77);
		push_request(OP_GET, 32'sd5, '0);
		drain();

		// two lines: extremes, hit, eviction, update
		write_capacity(2);
		push_request(OP_SET, key_pool[0], key_pool[1]);
		push_request(OP_SET, key_pool[1], key_pool[0]);
		push_request(OP_GET, key_pool[0], '1);
		push_request(OP_SET, key_pool[3], '1);
		push_request(OP_GET, key_pool[1], '0);
		push_request(OP_GET, key_pool[3], '0);
		push_request(OP_GET, key_pool[0], '0);
		push_request(OP_SET, key_pool[0], '0);
		push_request(OP_GET, key_pool[0], '0);
		push_request(OP_GET, key_pool[2], '0);
		push_request(OP_SET, key_pool[2], key_pool[0]);
		push_request(OP_GET, key_pool[2], '0);
		drain();

		// capacity lowered below the used count: replace instead of fill
		write_capacity(1);
		push_request(OP_SET, key_pool[4], key_pool[5]);
		push_request(OP_GET, key_pool[2], '0);
		push_request(OP_GET, key_pool[0], '0);
		push_request(OP_GET, key_pool[4], '0);
		push_request(OP_SET, key_pool[6], '1);
		push_request(OP_GET, key_pool[6], '0);
		drain();

		// random phases over capacity, key spread and sender gaps
		random_phase(31, 0, 130, 24);
		random_phase(16, 72, 130, 24);
		random_phase(4, 22, 130, 8);
		random_phase(0, 0, 120, 6);
		random_phase(1, 72, 120, 3);
		random_phase(8, 22, 130, 12);
		random_phase(16, 0, 140, POOL_SIZE);

		$display("Run covered %0d transactions over %0d capacity writes (0, 1, 2, 4, 8, 16, 31).",
			accepted_count, cap_writes);
		$display("Lookups answered: %0d hits, %0d misses.", hit_count, miss_count);
		if (error_count == 0 && expected_lookups.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
